FILE: rtl/msdc_pkg.sv
package msdc_pkg;

  // Field widths.
  localparam int unsigned PER_W   = 16;
  localparam int unsigned SP_W    = 10;
  localparam int unsigned RPM_W   = 16;
  localparam int unsigned RC_W    = 20;
  localparam int unsigned MR_W    = 16;
  localparam int unsigned DB_W    = 10;
  localparam int unsigned GAIN_W  = 4;
  localparam int unsigned SH_W    = 4;
  localparam int unsigned DUTY_W  = 12;
  localparam int unsigned CODE_W  = 10;

  // Duty code resolution.
  localparam int unsigned DUTY_BITS = 10;
  localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;

  // Configuration port.
  localparam int unsigned APB_DW = 32;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned IDX_W  = ADDR_W - 2;

  typedef enum logic [IDX_W-1:0] {
    REG_RPM_CONSTANT = 3'd0,
    REG_MAX_RPM      = 3'd1,
    REG_DEADBAND     = 3'd2,
    REG_GAIN         = 3'd3,
    REG_SHIFT        = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [RC_W-1:0]   rpm_constant;
    logic [MR_W-1:0]   max_rpm;
    logic [DB_W-1:0]   error_deadband;
    logic [GAIN_W-1:0] proportional_gain;
    logic [SH_W-1:0]   period_term_shift;
  } cfg_t;

  // Pipeline layout: quotient bits resolved per divider stage.
  localparam int unsigned STEPS    = 4;
  localparam int unsigned D1       = (RC_W + STEPS - 1) / STEPS;
  localparam int unsigned D2       = (DUTY_BITS + STEPS - 1) / STEPS;
  localparam int unsigned T_RPM    = D1;
  localparam int unsigned T_OVF    = D1 + 1;
  localparam int unsigned T_DIV2   = D1 + 2;
  localparam int unsigned T_ERR    = T_DIV2 + D2;
  localparam int unsigned T_MUL    = T_ERR + 1;
  localparam int unsigned T_COR    = T_ERR + 2;
  localparam int unsigned NUM_STAGES = T_COR + 2;

  // Derived arithmetic widths.
  localparam int unsigned NUM_W   = RPM_W + DUTY_BITS;
  localparam int unsigned ERR_W   = ((DUTY_BITS > SP_W) ? DUTY_BITS : SP_W) + 1;
  localparam int unsigned PROD_W  = SP_W + PER_W;
  localparam int unsigned GPROD_W = GAIN_W + SP_W;
  localparam int unsigned SUM_W   = PROD_W + 1;
  localparam int unsigned DUTY_OW = ((DUTY_BITS + 2) > DUTY_W) ? (DUTY_BITS + 2) : DUTY_W;
  localparam int unsigned CODE_OW = (DUTY_BITS > CODE_W) ? DUTY_BITS : CODE_W;

  typedef struct packed {
    logic [PER_W-1:0]     period;
    logic [SP_W-1:0]      setpoint;
    logic [RPM_W-1:0]     rem;
    logic [RC_W-1:0]      quo;
    logic [RPM_W-1:0]     rpm;
    logic [NUM_W-1:0]     num;
    logic                 ovf;
    logic [DUTY_BITS-1:0] code;
    logic                 issue;
    logic [SP_W-1:0]      e;
    logic [PROD_W-1:0]    prod;
    logic [GPROD_W-1:0]   gprod;
    logic [DUTY_W-1:0]    duty;
  } stage_t;

endpackage

FILE: rtl/msdc_if.sv
interface msdc_in_if;
  import msdc_pkg::*;

  logic             valid;
  logic             ready;
  logic [PER_W-1:0] period_count;
  logic [SP_W-1:0]  speed_setpoint;

  modport source (output valid, period_count, speed_setpoint, input ready);
  modport sink (input valid, period_count, speed_setpoint, output ready);
endinterface

interface msdc_out_if;
  import msdc_pkg::*;

  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty_word;
  logic [CODE_W-1:0] measured_speed_code;
  logic [RPM_W-1:0]  measured_rpm;

  modport source (output valid, duty_word, measured_speed_code, measured_rpm, input ready);
  modport sink (input valid, duty_word, measured_speed_code, measured_rpm, output ready);
endinterface

FILE: rtl/msdc_regs.sv
module msdc_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msdc_pkg::ADDR_W-1:0]   paddr,
  input  logic [msdc_pkg::APB_DW-1:0]   pwdata,
  output logic [msdc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output msdc_pkg::cfg_t                cfg_o
);
  import msdc_pkg::*;

  cfg_t             cfg_q;
  logic             wr_en;
  logic [IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[ADDR_W-1:2];
  assign cfg_o  = cfg_q;

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rpm_constant      <= RC_W'(36600);
      cfg_q.max_rpm           <= MR_W'(5000);
      cfg_q.error_deadband    <= DB_W'(15);
      cfg_q.proportional_gain <= GAIN_W'(2);
      cfg_q.period_term_shift <= SH_W'(12);
    end else if (wr_en) begin
      case (idx)
        REG_RPM_CONSTANT: cfg_q.rpm_constant      <= pwdata[RC_W-1:0];
        REG_MAX_RPM:      cfg_q.max_rpm           <= pwdata[MR_W-1:0];
        REG_DEADBAND:     cfg_q.error_deadband    <= pwdata[DB_W-1:0];
        REG_GAIN:         cfg_q.proportional_gain <= pwdata[GAIN_W-1:0];
        REG_SHIFT:        cfg_q.period_term_shift <= pwdata[SH_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, zero extended.
  always_comb begin
    case (idx)
      REG_RPM_CONSTANT: prdata = APB_DW'(cfg_q.rpm_constant);
      REG_MAX_RPM:      prdata = APB_DW'(cfg_q.max_rpm);
      REG_DEADBAND:     prdata = APB_DW'(cfg_q.error_deadband);
      REG_GAIN:         prdata = APB_DW'(cfg_q.proportional_gain);
      REG_SHIFT:        prdata = APB_DW'(cfg_q.period_term_shift);
      default:          prdata = '0;
    endcase
  end

endmodule

FILE: rtl/motor_speed_duty_correction.sv
// Motor speed duty correction.
// Input transactions on in_i carry an encoder period count and a speed
// setpoint. The block divides rpm_constant by the period (saturating at
// 65535), scales the rpm to a duty code against max_rpm, and when the
// setpoint exceeds the measured code by more than the deadband it issues one
// output transaction on out_o with the inverted, corrected duty word, the
// speed code and the rpm. Items inside the deadband produce no transaction.
// Configuration is to be written over the APB-style port only while no item
// is pending; the block itself does not enforce this. Throughput is one item
// per cycle while out_o is not stalled: both dividers are restoring dividers
// unrolled over pipeline stages, four quotient bits per stage. From acceptance
// to out_o.valid an item passes, with a 10-bit duty code, the five rpm divider
// stages, the rpm saturation and code range stages, three speed code divider
// stages, and the error, multiply and correction stages.
// When the receiver stalls, items close up behind the output register and
// in_i.ready falls only once every stage holds an item.
// Reset clears all stage valid bits and loads the default configuration.
module motor_speed_duty_correction (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  msdc_in_if.sink                       in_i,
  msdc_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msdc_pkg::ADDR_W-1:0]   paddr,
  input  logic [msdc_pkg::APB_DW-1:0]   pwdata,
  output logic [msdc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import msdc_pkg::*;

  cfg_t                  cfg;
  stage_t                in_stage;
  stage_t                pipe_q [NUM_STAGES];
  stage_t                pipe_d [NUM_STAGES];
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] valid_d;
  logic [NUM_STAGES-1:0] rdy;
  logic [CODE_OW-1:0]    code_ext;

  // One pipeline step, selected by the stage position.
  function automatic stage_t stage_next(int unsigned t, stage_t s, cfg_t c);
    stage_t               n;
    logic [RPM_W:0]       sh;
    logic                 qbit;
    logic [RPM_W-1:0]     dvs;
    int unsigned          first;
    int unsigned          total;
    logic [ERR_W-1:0]     err;
    logic [SUM_W-1:0]     sum;
    logic [DUTY_BITS-1:0] corr;
    logic [DUTY_OW-1:0]   duty_wide;
    n = s;
    if (t < T_RPM || (t >= T_DIV2 && t < T_ERR)) begin
      // Restoring division, up to four quotient bits.
      if (t < T_RPM) begin
        first = t * STEPS;
        total = RC_W;
        dvs   = s.period;
      end else begin
        first = (t - T_DIV2) * STEPS;
        total = DUTY_BITS;
        dvs   = c.max_rpm;
      end
      for (int j = 0; j < STEPS; j++) begin
        if (first + j < total) begin
          sh   = {n.rem, n.quo[RC_W-1]};
          qbit = (sh >= {1'b0, dvs});
          if (qbit) begin
            sh = sh - {1'b0, dvs};
          end
          n.rem = sh[RPM_W-1:0];
          n.quo = {n.quo[RC_W-2:0], qbit};
        end
      end
    end else if (t == T_RPM) begin
      // Saturate the rpm and form rpm * DUTY_MAX.
      n.rpm = (|s.quo[RC_W-1:RPM_W]) ? '1 : s.quo[RPM_W-1:0];
      n.num = {n.rpm, {DUTY_BITS{1'b0}}} - NUM_W'(n.rpm);
    end else if (t == T_OVF) begin
      // A quotient beyond the code range shows in the upper bits alone.
      n.ovf = (s.num[NUM_W-1:DUTY_BITS] >= c.max_rpm);
      n.rem = s.num[NUM_W-1:DUTY_BITS];
      n.quo = {s.num[DUTY_BITS-1:0], {(RC_W-DUTY_BITS){1'b0}}};
    end else if (t == T_ERR) begin
      // Speed code, error and deadband test.
      n.code  = s.ovf ? DUTY_MAX : s.quo[DUTY_BITS-1:0];
      err     = ERR_W'(s.setpoint) - ERR_W'(n.code);
      n.issue = !err[ERR_W-1] && (err[ERR_W-2:0] > (ERR_W-1)'(c.error_deadband));
      n.e     = err[SP_W-1:0];
    end else if (t == T_MUL) begin
      n.prod  = PROD_W'(s.e) * PROD_W'(s.period);
      n.gprod = GPROD_W'(c.proportional_gain) * GPROD_W'(s.e);
    end else begin
      // Correction, clamp and inverted duty word.
      sum       = SUM_W'(s.prod >> c.period_term_shift) + SUM_W'(s.gprod);
      corr      = (sum > SUM_W'(DUTY_MAX)) ? DUTY_MAX : sum[DUTY_BITS-1:0];
      duty_wide = DUTY_OW'({DUTY_MAX - corr, 2'b00});
      n.duty    = duty_wide[DUTY_W-1:0];
    end
    return n;
  endfunction

  msdc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stage zero loads the divider with the numerator.
  always_comb begin
    in_stage          = '0;
    in_stage.period   = in_i.period_count;
    in_stage.setpoint = in_i.speed_setpoint;
    in_stage.quo      = cfg.rpm_constant;
  end

  assign pipe_d[0]  = in_stage;
  assign valid_d[0] = in_i.valid;

  // Later stages; items inside the deadband drop out before the output.
  for (genvar k = 1; k < NUM_STAGES; k++) begin : g_stage
    assign pipe_d[k]  = stage_next(k - 1, pipe_q[k-1], cfg);
    assign valid_d[k] = valid_q[k-1] && ((k - 1 != T_COR) || pipe_q[k-1].issue);
  end

  // A stage takes a new item when it is empty or its item moves on.
  assign rdy[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_o.ready;
  for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_rdy
    assign rdy[k] = !valid_q[k] || rdy[k+1];
  end

  assign in_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= valid_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (rdy[k]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  // Output register is the last stage.
  assign code_ext                  = CODE_OW'(pipe_q[NUM_STAGES-1].code);
  assign out_o.valid               = valid_q[NUM_STAGES-1];
  assign out_o.duty_word           = pipe_q[NUM_STAGES-1].duty;
  assign out_o.measured_speed_code = code_ext[CODE_W-1:0];
  assign out_o.measured_rpm        = pipe_q[NUM_STAGES-1].rpm;

endmodule

FILE: rtl/msdc_checker.sv
module msdc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [msdc_pkg::DUTY_W-1:0] duty_word,
  input logic [msdc_pkg::CODE_W-1:0] measured_speed_code
);
  import msdc_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output transaction withdrawn under stall");

  // The input side stalls only when the output is full and blocked.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while the pipeline has room");

  // The duty word is always a multiple of four.
  a_duty_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> duty_word[1:0] == 2'b00)
    else $error("duty word has low bits set");

  // A correction needs a code below the setpoint, so never full scale.
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> measured_speed_code != {CODE_W{1'b1}})
    else $error("correction issued at full scale speed code");

endmodule

bind motor_speed_duty_correction msdc_checker u_msdc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_ready            (in_i.ready),
  .out_valid           (out_o.valid),
  .out_ready           (out_o.ready),
  .duty_word           (out_o.duty_word),
  .measured_speed_code (out_o.measured_speed_code)
);
